// ===== rtl/core/rea_pkg.sv =====
// Shared types and constants for the rotary encoder acceleration block.
// Holds the register indexes, reset values and the structs between modules.
// No dependencies.
package rea_pkg;

  localparam int DacBitsDef  = 12;
  localparam int TimeBitsDef = 16;

  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] CFG_SETTLE_TICKS = 4'd0;
  localparam logic [CfgAddrW-1:0] CFG_FAST_CLICK   = 4'd1;
  localparam logic [CfgAddrW-1:0] CFG_ACCEL_MAX    = 4'd2;
  localparam logic [CfgAddrW-1:0] CFG_DAC_MAX      = 4'd3;

  localparam logic [7:0]  SETTLE_RST  = 8'd2;
  localparam logic [15:0] FAST_RST    = 16'd250;
  localparam logic [6:0]  ACCEL_RST   = 7'd100;
  localparam logic [11:0] DAC_MAX_RST = 12'd4095;

  localparam logic [7:0] EDGE_MAX = 8'd255;

  typedef enum logic [1:0] {
    PH_DOWN = 2'b01,
    PH_UP   = 2'b10
  } rea_phase_e;

  typedef struct packed {
    logic [7:0]  settle_ticks;
    logic [15:0] fast_click_ticks;
    logic [6:0]  accel_max;
    logic [11:0] dac_max;
  } rea_cfg_t;

  typedef struct packed {
    logic processed;
    logic pending_nxt;
    logic click;
    logic down;
  } rea_evt_t;

endpackage

// ===== rtl/core/rea_cfg.sv =====
// Configuration registers of the rotary encoder block.
// Depends on rea_pkg.
module rea_cfg
  import rea_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output rea_cfg_t            cfg_o
);

  rea_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_SETTLE_TICKS: cfg_d.settle_ticks     = cfg_data_i[7:0];
        CFG_FAST_CLICK:   cfg_d.fast_click_ticks = cfg_data_i[15:0];
        CFG_ACCEL_MAX:    cfg_d.accel_max        = cfg_data_i[6:0];
        CFG_DAC_MAX:      cfg_d.dac_max          = cfg_data_i[11:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks     <= SETTLE_RST;
      cfg_q.fast_click_ticks <= FAST_RST;
      cfg_q.accel_max        <= ACCEL_RST;
      cfg_q.dac_max          <= DAC_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/rea_quad.sv =====
// Edge watch, settling counter and half-cycle tracking on channel A.
// Depends on rea_pkg; reports processed edges and clicks as rea_evt_t.
module rea_quad
  import rea_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       pin_a_i,
  input  logic       pin_b_i,
  input  logic [7:0] settle_ticks_i,
  output rea_evt_t   evt_o
);

  rea_phase_e phase_d, phase_q;
  logic       last_a_d, last_a_q;
  logic       pend_d, pend_q;
  logic [7:0] since_d, since_q;
  logic [7:0] since_inc;
  logic       is_down, edge_seen, settled;

  assign is_down   = (phase_q == PH_DOWN);
  assign edge_seen = is_down ? (last_a_q & ~pin_a_i) : (~last_a_q & pin_a_i);
  assign since_inc = (since_q < EDGE_MAX) ? since_q + 8'd1 : since_q;
  assign settled   = (since_inc > settle_ticks_i) || (since_inc == EDGE_MAX);

  always_comb begin
    phase_d         = phase_q;
    pend_d          = pend_q;
    since_d         = since_q;
    last_a_d        = pin_a_i;
    evt_o.processed = 1'b0;
    evt_o.click     = 1'b0;
    evt_o.down      = pin_b_i;
    if (edge_seen) begin
      pend_d  = 1'b1;
      since_d = 8'd0;
    end else if (pend_q) begin
      since_d = since_inc;
      if (settled) begin
        pend_d          = 1'b0;
        evt_o.processed = 1'b1;
        if (is_down && !pin_a_i) begin
          phase_d = PH_UP;
        end else begin
          evt_o.click = !is_down && pin_a_i;
          phase_d     = PH_DOWN;
        end
      end
    end
    evt_o.pending_nxt = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DOWN;
      last_a_q <= 1'b1;
      pend_q   <= 1'b0;
      since_q  <= 8'd0;
    end else if (en_i) begin
      phase_q  <= phase_d;
      last_a_q <= last_a_d;
      pend_q   <= pend_d;
      since_q  <= since_d;
    end
  end

endmodule

// ===== rtl/core/rea_accel.sv =====
// Click interval timing, acceleration factor and saturated setpoint.
// Depends on rea_pkg; takes events from rea_quad.
module rea_accel
  import rea_pkg::*;
#(
  parameter int DAC_BITS  = DacBitsDef,
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  rea_evt_t            evt_i,
  input  rea_cfg_t            cfg_i,
  output logic                emit_o,
  output logic [DAC_BITS-1:0] setpoint_o
);

  localparam int CmpW = TIME_BITS + 16;

  logic [TIME_BITS-1:0] sc_d, sc_q, sc_inc;
  logic [6:0]           fac_d, fac_q;
  logic [DAC_BITS-1:0]  sp_d, sp_q, top;
  logic                 sent_q;

  logic [CmpW-1:0]        sc_cmp, fast_cmp;
  logic [DAC_BITS+11:0]   top_w;
  logic [7:0]             f_step, lim;
  logic [DAC_BITS:0]      fac_w, sp_w, nv;

  assign sc_inc   = (sc_q != {TIME_BITS{1'b1}}) ? sc_q + 1'b1 : sc_q;
  assign sc_cmp   = {16'd0, sc_inc};
  assign fast_cmp = {{TIME_BITS{1'b0}}, cfg_i.fast_click_ticks};
  assign top_w    = {{DAC_BITS{1'b0}}, cfg_i.dac_max};
  assign top      = top_w[DAC_BITS-1:0];
  assign lim      = (cfg_i.accel_max == 7'd0) ? 8'd1 : {1'b0, cfg_i.accel_max};
  assign sp_w     = {1'b0, sp_q};

  always_comb begin
    sc_d   = sc_inc;
    fac_d  = fac_q;
    sp_d   = sp_q;
    f_step = {1'b0, fac_q};
    fac_w  = '0;
    nv     = sp_w;
    if (evt_i.click) begin
      if (sc_cmp < fast_cmp) begin
        f_step = {1'b0, fac_q} + 8'd1;
      end else if (fac_q != 7'd0) begin
        f_step = {1'b0, fac_q} - 8'd1;
      end
      if (f_step < 8'd1) begin
        f_step = 8'd1;
      end
      if (f_step > lim) begin
        f_step = lim;
      end
      fac_d = f_step[6:0];
      sc_d  = '0;
      fac_w = {{(DAC_BITS-6){1'b0}}, f_step[6:0]};
      if (evt_i.down) begin
        nv = (sp_w > fac_w) ? sp_w - fac_w : '0;
      end else begin
        nv = sp_w + fac_w;
      end
      if (nv > {1'b0, top}) begin
        nv = {1'b0, top};
      end
      sp_d = nv[DAC_BITS-1:0];
    end else if (!evt_i.pending_nxt && !evt_i.processed && (sc_cmp > fast_cmp)) begin
      fac_d = (fac_q > 7'd1) ? fac_q - 7'd1 : 7'd1;
    end
  end

  assign emit_o     = !sent_q || (sp_d != sp_q);
  assign setpoint_o = sp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q   <= '0;
      fac_q  <= 7'd1;
      sp_q   <= '0;
      sent_q <= 1'b0;
    end else if (en_i) begin
      sc_q   <= sc_d;
      fac_q  <= fac_d;
      sp_q   <= sp_d;
      sent_q <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/rotary_encoder_accel_dac.sv =====
// Rotary encoder with click acceleration driving a DAC setpoint. One item is
// one time tick of sampled A/B pin levels; the block takes one item per clock
// cycle. An item passes an input register, then the per-tick state update
// (edge settling, acceleration, saturated setpoint) is combinational into the
// result register, loaded only for the first item and on a setpoint change.
// Input stalls only while the result register is full and not being taken.
// Depends on rea_pkg, rea_cfg, rea_quad and rea_accel.
module rotary_encoder_accel_dac
  import rea_pkg::*;
#(
  parameter int DAC_BITS  = DacBitsDef,
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                pin_a_i,
  input  logic                pin_b_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DAC_BITS-1:0] dac_code_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  rea_cfg_t            cfg;
  rea_evt_t            evt;
  logic                in_valid_q, a_q, b_q;
  logic                out_valid_d, out_valid_q;
  logic [DAC_BITS-1:0] code_q, setpoint;
  logic                fire, emit;

  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign cfg_ready_o = 1'b1;

  rea_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rea_quad u_quad (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (fire),
    .pin_a_i        (a_q),
    .pin_b_i        (b_q),
    .settle_ticks_i (cfg.settle_ticks),
    .evt_o          (evt)
  );

  rea_accel #(
    .DAC_BITS  (DAC_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_accel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (fire),
    .evt_i      (evt),
    .cfg_i      (cfg),
    .emit_o     (emit),
    .setpoint_o (setpoint)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_q <= pin_a_i;
      b_q <= pin_b_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      code_q <= setpoint;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dac_code_o  = code_q;

endmodule

// ===== rtl/core/rea_checker.sv =====
// Port-level checks for rotary_encoder_accel_dac, bound to the top level.
// Depends on rea_pkg for the default widths.
module rea_checker
  import rea_pkg::*;
#(
  parameter int DAC_BITS = DacBitsDef
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [DAC_BITS-1:0] dac_code_o
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dac_code_o))
    else $error("result item changed while stalled");

  // input stalls only behind a full, stalled result register
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind rotary_encoder_accel_dac rea_checker #(
  .DAC_BITS (DAC_BITS)
) u_rea_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .dac_code_o  (dac_code_o)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for rotary_encoder_accel_dac: pin ticks go in, DAC codes come out.
// A tick-level predictor computes the codes, which are checked under random flow control.
// Depends on rea_pkg and the RTL of the block.
module tb;
  import rea_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic a;
    logic b;
  } tick_t;

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_PERIODIC,
    RX_MOSTLY
  } rx_mode_e;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_vld    = 1'b0;
  logic                in_ready_o;
  logic                pin_a     = 1'b1;
  logic                pin_b     = 1'b0;
  logic                out_valid_o;
  logic                out_rdy   = 1'b0;
  logic [11:0]         dac_code_o;
  logic                cfg_vld   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // register copies
  logic [7:0]  c_settle    = SETTLE_RST;
  logic [15:0] c_fast      = FAST_RST;
  logic [6:0]  c_accel_max = ACCEL_RST;
  logic [11:0] c_dac_max   = DAC_MAX_RST;

  // encoder state copy
  logic        half_down  = 1'b1;
  logic        edge_wait  = 1'b0;
  logic        prev_a     = 1'b1;
  logic [7:0]  settle_cnt = '0;
  logic [15:0] click_gap  = '0;
  logic [6:0]  accel      = 7'd1;
  logic [11:0] level      = '0;
  logic        first_done = 1'b0;

  tick_t       pending_ticks[$];
  logic [11:0] dac_codes_exp[$];
  logic [11:0] exp_code;
  tick_t       nxt;

  int err_cnt = 0, n_items = 0, n_codes = 0, n_writes = 0;
  int burst_left = 0, gap_left = 0;
  int rx_left = 0, rx_hold = 0;
  rx_mode_e rx_mode = RX_FREE;
  bit hold_req = 1'b0, hold_done = 1'b0;

  rotary_encoder_accel_dac u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_vld),
    .in_ready_o (in_ready_o),
    .pin_a_i    (pin_a),
    .pin_b_i    (pin_b),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_rdy),
    .dac_code_o (dac_code_o),
    .cfg_valid_i(cfg_vld),
    .cfg_ready_o(cfg_ready_o),
    .cfg_addr_i (cfg_addr),
    .cfg_data_i (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // one tick of the encoder: settling, click, acceleration, saturated setpoint
  task automatic encoder_tick(input logic a, input logic b);
    logic [11:0] old_level;
    logic        hit, settled;
    int          lim, f, lv, nv;
    old_level = level;
    settled   = 1'b0;
    if (click_gap != 16'hFFFF) click_gap++;
    hit    = half_down ? (prev_a && !a) : (!prev_a && a);
    prev_a = a;
    if (hit) begin
      edge_wait  = 1'b1;
      settle_cnt = '0;
    end else if (edge_wait) begin
      if (settle_cnt != EDGE_MAX) settle_cnt++;
      if (settle_cnt > c_settle || settle_cnt == EDGE_MAX) begin
        if (half_down && !a) begin
          half_down = 1'b0;
        end else begin
          if (!half_down && a) begin
            lim = (c_accel_max == 0) ? 1 : int'(c_accel_max);
            f   = int'(accel);
            if (click_gap < c_fast) f++;
            else if (f > 0) f--;
            if (f < 1) f = 1;
            if (f > lim) f = lim;
            accel     = f[6:0];
            click_gap = '0;
            lv        = int'(level);
            if (b) nv = (lv > f) ? lv - f : 0;
            else nv = lv + f;
            if (nv > int'(c_dac_max)) nv = int'(c_dac_max);
            level = nv[11:0];
          end
          half_down = 1'b1;
        end
        edge_wait = 1'b0;
        settled   = 1'b1;
      end
    end
    if (!edge_wait && !settled && click_gap > c_fast && accel > 7'd1) accel--;
    if (!first_done || level != old_level) begin
      first_done = 1'b1;
      dac_codes_exp.push_back(level);
    end
  endtask

  task automatic push_tick(input logic a, input logic b);
    tick_t t;
    t.a = a;
    t.b = b;
    pending_ticks.push_back(t);
  endtask

  // full down-then-up cycle, optionally with a bounce right after the falling edge
  task automatic push_click(input logic down, input logic noisy);
    int n;
    n = (c_settle >= 8'd254) ? 255 : int'(c_settle) + 1;
    push_tick(1'b0, 1'($urandom_range(0, 1)));
    if (noisy) begin
      push_tick(1'b1, 1'($urandom_range(0, 1)));
      push_tick(1'b0, 1'($urandom_range(0, 1)));
    end
    repeat (n) push_tick(1'b0, 1'($urandom_range(0, 1)));
    push_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (n - 1) push_tick(1'b1, 1'($urandom_range(0, 1)));
    push_tick(1'b1, down);
  endtask

  task automatic push_mix(input int clicks, input int up_pct, input int idle_max);
    int r;
    for (int i = 0; i < clicks; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        repeat ($urandom_range(1, 6)) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        push_tick(1'b1, 1'($urandom_range(0, 1)));
      end else if (r == 1) begin
        repeat ($urandom_range(1, idle_max)) push_tick(1'b1, 1'($urandom_range(0, 1)));
      end
      push_click(1'($urandom_range(0, 99) >= up_pct), 1'($urandom_range(0, 3) == 0));
    end
  endtask

  task automatic cfg_write(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_vld  <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_vld <= 1'b0;
    case (addr)
      CFG_SETTLE_TICKS: c_settle    = data[7:0];
      CFG_FAST_CLICK:   c_fast      = data[15:0];
      CFG_ACCEL_MAX:    c_accel_max = data[6:0];
      CFG_DAC_MAX:      c_dac_max   = data[11:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic write_regs(input int settle, input int fast, input int amax, input int dmax);
    cfg_write(CFG_SETTLE_TICKS, CfgDataW'(settle));
    cfg_write(CFG_FAST_CLICK, CfgDataW'(fast));
    cfg_write(CFG_ACCEL_MAX, CfgDataW'(amax));
    cfg_write(CFG_DAC_MAX, CfgDataW'(dmax));
  endtask

  // all items taken and all codes seen, then a wait for ticks still in flight without a code
  task automatic wait_idle();
    while (pending_ticks.size() != 0 || in_vld || dac_codes_exp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // sender: bursts of items with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_vld && in_ready_o) begin
        encoder_tick(pin_a, pin_b);
        n_items++;
      end
      if (!in_vld || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_vld <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          nxt = pending_ticks.pop_front();
          in_vld <= 1'b1;
          pin_a  <= nxt.a;
          pin_b  <= nxt.b;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_vld <= 1'b0;
        end
      end
    end
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_rdy <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      rx_hold   = 400;
      out_rdy <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_FREE:     out_rdy <= 1'b1;
        RX_COIN:     out_rdy <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_rdy <= (rx_left % 4) != 0;
        default:     out_rdy <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_rdy) begin
      n_codes++;
      if (dac_codes_exp.size() == 0) begin
        err_cnt++;
        $display("%0t: expected no dac_code, actual %0d", $time, dac_code_o);
      end else begin
        exp_code = dac_codes_exp.pop_front();
        if (dac_code_o !== exp_code) begin
          err_cnt++;
          $display("%0t: dac_code expected %0d, actual %0d", $time, exp_code, dac_code_o);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first code after reset, up and down clicks, zero floor, restarted settling
    write_regs(SETTLE_RST, FAST_RST, ACCEL_RST, DAC_MAX_RST);
    push_tick(1'b1, 1'b1);
    push_click(1'b0, 1'b0);
    push_click(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b0);
    wait_idle();

    // fast clicks building the factor up, long receiver hold-off
    write_regs(0, 16'hFFFF, 127, 4095);
    push_mix(45, 95, 8);
    hold_req = 1'b1;
    wait_idle();

    // limits lowered below current factor and setpoint
    write_regs(1, 16'hFFFF, 3, 100);
    push_mix(15, 50, 8);
    wait_idle();

    // zero limits: every click saturates, factor always decays
    write_regs(0, 0, 0, 0);
    push_mix(15, 50, 8);
    wait_idle();

    // longest settling
    write_regs(255, 600, 127, 2048);
    push_click(1'b0, 1'b0);
    wait_idle();

    repeat (2) begin
      write_regs($urandom_range(0, 3), $urandom_range(0, 40), $urandom_range(1, 127),
                 $urandom_range(0, 4095));
      push_mix(15, 60, 40);
      wait_idle();
    end

    write_regs(SETTLE_RST, FAST_RST, ACCEL_RST, DAC_MAX_RST);
    push_mix(9, 55, 280);
    wait_idle();

    $display("Ran %0d ticks through %0d register writes, %0d DAC codes checked, %0d errors",
             n_items, n_writes, n_codes, err_cnt);
    if (err_cnt == 0 && dac_codes_exp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
